[design/vcp_pkg.sv]
package vcp_pkg;

   // Default size of the channel table.
   localparam int unsigned DEFAULT_CHANNELS = 64;

   // Field widths of the request, the result and the table entries.
   localparam int unsigned ENT_W = 10;
   localparam int unsigned SUB_W = 3;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned IDX_W = 6;
   localparam int unsigned NUM_W = 7;

   // Streaming mask covers the first channels only.
   localparam int unsigned MASK_W = 64;

   // Stream payload widths (whole bytes).
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 8;

   // Register port.
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 64;

   // Register indexes (byte address is 8 times the index).
   localparam logic [1:0] REG_NUM_CHANNELS = 2'd0;
   localparam logic [1:0] REG_PLAYER_ENTITY = 2'd1;
   localparam logic [1:0] REG_STREAMING_MASK = 2'd2;

   // Request operations.
   localparam logic OP_PICK = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // One entry of the channel owner table.
   typedef struct packed {
      logic [ENT_W-1:0] ent;
      logic [SUB_W-1:0] sub;
      logic [TIME_W-1:0] stamp;
   } entry_type;

endpackage

[design/voice_channel_picker_core.sv]
// Voice channel picker. A request on the req_ stream either picks a mixer
// channel for a sound (tuser low) or releases one (tuser high); each request
// gives exactly one item on the rsp_ stream. A pick walks the channel table in
// index order, one channel per clock through the single read port of the owner
// table: it stops at the first idle channel or at the first channel where the
// same entity already plays on the same nonzero sub-channel, and otherwise
// steals the channel with the strictly oldest start time, never a channel
// started at the current time and never a player channel for another entity.
// Channels marked in the streaming mask are skipped. A pick judges at most the
// N live channels, then passes through ST_FINISH to ST_RESP; it ends sooner
// when an idle or matching channel turns up early. A release shows its result
// in the cycle after it is taken. The block takes one request at a time
// and holds req_tready low until the result has been taken. The user must
// write the csr_ port registers only while no request is in flight (not enforced).
module voice_channel_picker_core #(
   parameter int unsigned CHANNELS = vcp_pkg::DEFAULT_CHANNELS
) (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0 up: ent_num[9:0], ent_channel[12:10], now_time[44:13],
   // channel_index[50:45], zero fill[55:51].
   input  logic [vcp_pkg::REQ_DATA_W-1:0] req_tdata,
   // Field: opcode (0 pick, 1 release).
   input  logic req_tuser,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0 up: found[0], granted_channel[6:1], stolen[7].
   output logic [vcp_pkg::RSP_DATA_W-1:0] rsp_tdata,

   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [vcp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [vcp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [vcp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   // Channel index width and a counter width that can hold the channel count.
   localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned CW = $clog2(CHANNELS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_RESP
   } state_type;

   // Configuration registers.
   logic [vcp_pkg::NUM_W-1:0] num_channels_ff;
   logic [vcp_pkg::ENT_W-1:0] player_ff;
   logic [vcp_pkg::MASK_W-1:0] mask_ff;

   // Sequencer state and the request held during the scan.
   state_type state_ff;
   logic op_ff;
   logic [vcp_pkg::ENT_W-1:0] ent_ff;
   logic [vcp_pkg::SUB_W-1:0] sub_ff;
   logic [vcp_pkg::TIME_W-1:0] now_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] issue_ff;
   logic eval_valid_ff;
   logic [IW-1:0] eval_idx_ff;
   logic have_ff;
   logic [IW-1:0] pick_ff;
   logic [vcp_pkg::TIME_W-1:0] oldest_ff;

   // Result register.
   logic rsp_found_ff;
   logic [vcp_pkg::IDX_W-1:0] rsp_chan_ff;
   logic rsp_stolen_ff;

   // Per-channel activity bits and the owner table.
   logic active_ff [CHANNELS];
   vcp_pkg::entry_type table_mem [CHANNELS];
   vcp_pkg::entry_type rd_data_ff;

   // Unpacked request fields.
   logic [vcp_pkg::ENT_W-1:0] req_ent;
   logic [vcp_pkg::SUB_W-1:0] req_sub;
   logic [vcp_pkg::TIME_W-1:0] req_now;
   logic [vcp_pkg::IDX_W-1:0] req_idx;

   logic req_fire;
   logic csr_write;
   logic [1:0] csr_reg;
   logic [CW-1:0] count_in;
   logic [8:0] num_wide;
   logic rd_en;
   logic wr_en;
   logic [8:0] eval_wide;
   logic [8:0] pick_wide;
   logic [8:0] rel_wide;
   logic eval_stream;
   logic eval_active;
   logic eval_match;
   logic eval_protected;
   logic eval_older;
   logic eval_last;
   logic eval_win;
   logic rel_in_range;

   assign req_ent = req_tdata[9:0];
   assign req_sub = req_tdata[12:10];
   assign req_now = req_tdata[44:13];
   assign req_idx = req_tdata[50:45];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata = {rsp_stolen_ff, rsp_chan_ff, rsp_found_ff};
   assign req_fire = req_tvalid && req_tready;

   // Register port: always ready, registers at 8-byte steps.
   assign csr_pready = 1'b1;
   assign csr_reg = csr_paddr[4:3];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_reg)
         vcp_pkg::REG_NUM_CHANNELS:   csr_prdata = 64'(num_channels_ff);
         vcp_pkg::REG_PLAYER_ENTITY:  csr_prdata = 64'(player_ff);
         vcp_pkg::REG_STREAMING_MASK: csr_prdata = mask_ff;
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_channels_ff <= vcp_pkg::NUM_W'(vcp_pkg::DEFAULT_CHANNELS);
         player_ff <= '0;
         mask_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_reg)
            vcp_pkg::REG_NUM_CHANNELS:   num_channels_ff <= csr_pwdata[6:0];
            vcp_pkg::REG_PLAYER_ENTITY:  player_ff <= csr_pwdata[9:0];
            vcp_pkg::REG_STREAMING_MASK: mask_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Live channel count: the register, limited to the table size.
   assign num_wide = 9'(num_channels_ff);
   assign count_in = (num_wide > 9'(CHANNELS)) ? CW'(CHANNELS) : CW'(num_wide);

   assign rel_wide = 9'(req_idx);
   assign rel_in_range = (rel_wide < 9'(count_in));

   // Evaluation of the channel whose table entry arrived this cycle.
   assign eval_wide = 9'(eval_idx_ff);
   assign pick_wide = 9'(pick_ff);
   assign eval_stream = (eval_wide < 9'(vcp_pkg::MASK_W)) && mask_ff[eval_wide[5:0]];
   assign eval_active = active_ff[eval_idx_ff];
   assign eval_match = (sub_ff != '0) && (rd_data_ff.ent == ent_ff) &&
                       (rd_data_ff.sub == sub_ff);
   assign eval_protected = (ent_ff != player_ff) && (rd_data_ff.ent == player_ff);
   assign eval_older = (rd_data_ff.stamp < oldest_ff);
   assign eval_last = ((eval_wide + 9'd1) == 9'(count_ff));
   assign eval_win = eval_valid_ff && !eval_stream && (!eval_active || eval_match);

   assign rd_en = (state_ff == ST_SCAN) && (issue_ff < count_ff);
   assign wr_en = (state_ff == ST_FINISH) && have_ff;

   // Owner table: one read and one write port, read data registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[issue_ff[IW-1:0]];
      end
      if (wr_en) begin
         table_mem[pick_ff] <= '{ent: ent_ff, sub: sub_ff, stamp: now_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         eval_valid_ff <= 1'b0;
         have_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            active_ff[i] <= 1'b0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff <= req_tuser;
                  ent_ff <= req_ent;
                  sub_ff <= req_sub;
                  now_ff <= req_now;
                  oldest_ff <= req_now;
                  count_ff <= count_in;
                  issue_ff <= '0;
                  eval_valid_ff <= 1'b0;
                  have_ff <= 1'b0;
                  pick_ff <= '0;
                  if (req_tuser == vcp_pkg::OP_RELEASE) begin
                     // Release: clear the activity bit, answer without a scan.
                     if (rel_in_range) begin
                        active_ff[rel_wide[IW-1:0]] <= 1'b0;
                     end
                     rsp_found_ff <= rel_in_range;
                     rsp_chan_ff <= rel_in_range ? req_idx : '0;
                     rsp_stolen_ff <= 1'b0;
                     state_ff <= ST_RESP;
                  end else if (count_in == '0) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               // Issue the next table read while the previous entry is judged.
               if (rd_en) begin
                  issue_ff <= issue_ff + CW'(1);
                  eval_idx_ff <= issue_ff[IW-1:0];
                  eval_valid_ff <= 1'b1;
               end else begin
                  eval_valid_ff <= 1'b0;
               end
               if (eval_win) begin
                  have_ff <= 1'b1;
                  pick_ff <= eval_idx_ff;
               end else if (eval_valid_ff && !eval_stream && !eval_protected &&
                            eval_older) begin
                  have_ff <= 1'b1;
                  pick_ff <= eval_idx_ff;
                  oldest_ff <= rd_data_ff.stamp;
               end
               if (eval_win || (eval_valid_ff && eval_last)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // Claim the chosen channel and form the result.
               eval_valid_ff <= 1'b0;
               rsp_found_ff <= have_ff;
               rsp_chan_ff <= have_ff ? pick_wide[5:0] : '0;
               rsp_stolen_ff <= have_ff && active_ff[pick_ff];
               if (have_ff) begin
                  active_ff[pick_ff] <= 1'b1;
               end
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_tready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // The read pointer never runs past the live channel count.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (issue_ff <= count_ff))
      else $error("scan pointer ran past the channel count");

   // Every judged channel lies inside the live range.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && eval_valid_ff) |-> (9'(eval_idx_ff) < 9'(count_ff)))
      else $error("judged channel outside the live range");

   // A granted pick leaves its channel marked active.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && have_ff) |=> active_ff[$past(pick_ff)])
      else $error("granted channel not marked active");

   // A release never reports a stolen channel.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && op_ff == vcp_pkg::OP_RELEASE) |-> !rsp_stolen_ff)
      else $error("release reported a stolen channel");

   // A pending result blocks new requests.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a result is pending");

endmodule
